@@ rtl/core/vpgqm_pkg.sv @@
`default_nettype none
package vpgqm_pkg;

  typedef struct packed {
    logic [11:0] texel_id;
    logic [2:0]  facing;
    logic [4:0]  plane_layer;
    logic        new_mesh;
  } in_item_t;

  typedef struct packed {
    logic [31:0] vertex0;
    logic [31:0] vertex1;
    logic [31:0] vertex2;
    logic [31:0] vertex3;
    logic        last_of_run;
    logic        overflow;
  } out_item_t;

  // group entry: id, start row, start col, end col
  typedef struct packed {
    logic [11:0] tid;
    logic [4:0]  sy;
    logic [4:0]  sx;
    logic [4:0]  ex;
  } group_t;

  localparam logic [15:0] CAP_RESET = 16'hffff;
  localparam logic [4:0]  COORD_MASK = 5'h1f;

  // configuration register byte addresses
  localparam logic [1:0] ADDR_QUAD_CAP = 2'd0;

  // controller -> datapath commands
  typedef struct packed {
    logic take_item;    // latch item, step open-run logic
    logic scan_step;    // compare one prev entry
    logic close_write;  // write the closed run into cur list
    logic emit_quad;    // load one quad into output reg
    logic emit_ovf;     // load overflow result
    logic swap_lists;   // end of row: cur becomes prev
    logic last_flag;    // quad being loaded is the last one
    logic batch_done;   // add batch count to quads_r
    logic final_batch;  // emitting last-row batch
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       need_close;
    logic       last_col;   // current column is the last of the row
    logic       last_row;   // current row is the last of the plane
    logic       scan_hit;
    logic       scan_last;
    logic       batch_empty;
    logic       cur_empty;  // current-row list holds no group
    logic       batch_ovf;
    logic       emit_last;
    logic       out_busy;
  } dp_stat_t;

  function automatic logic [2:0] corner_code(input logic [2:0] f, input logic [1:0] j);
    logic [2:0] c;
    begin
      c = 3'b000;
      case (f)
        3'd0: c = {1'b1, j};
        3'd1: c = {1'b0, j[0], j[1]};
        3'd2: c = {j[0], 1'b1, j[1]};
        3'd3: c = {j[1], 1'b0, j[0]};
        3'd4: c = {j[1], j[0], 1'b1};
        default: c = {j[0], j[1], 1'b0};
      endcase
      return c;
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/vpgqm_dp.sv @@
`default_nettype none
module vpgqm_dp #(
  parameter int PLANE_SIZE = 32,
  parameter int TEX_BITS   = 12
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  vpgqm_pkg::in_item_t   in_data,
  input  vpgqm_pkg::dp_cmd_t    cmd,
  input  wire  [15:0]           quad_capacity,
  input  wire                   out_ready,
  output vpgqm_pkg::dp_stat_t   stat,
  output logic                  out_valid,
  output vpgqm_pkg::out_item_t  out_data
);
  localparam int IW = $clog2(PLANE_SIZE);
  localparam int CW = IW + 1;
  localparam logic [4:0] LAST = 5'(PLANE_SIZE - 1);

  vpgqm_pkg::group_t mem_a [PLANE_SIZE];
  vpgqm_pkg::group_t mem_b [PLANE_SIZE];
  logic              sel_r, sel_nxt;   // 1: mem_b is prev
  logic [CW-1:0]     prev_cnt_r, cur_cnt_r;
  logic [11:0]       run_id_r;
  logic [4:0]        run_sx_r, run_sy_r;
  logic [4:0]        col_r, row_r;
  logic [15:0]       quads_r;
  logic              ovf_r;
  logic [CW-1:0]     idx_r;
  logic [2:0]        facing_r;
  logic [4:0]        layer_r;
  // pending close
  logic [11:0]       cl_id_r;
  logic [4:0]        cl_sx_r, cl_sy_r, cl_ex_r;
  logic              cl_a_r, cl_b_r;   // close ahead of / at row end
  logic [4:0]        emit_row_r;
  logic              out_valid_r;
  vpgqm_pkg::out_item_t out_r;

  // item decode
  logic [11:0] tex;
  logic [2:0]  fac;
  logic [4:0]  run_base_id_sy;
  logic [11:0] eff_id;
  always_comb begin
    tex = 12'(in_data.texel_id[TEX_BITS-1:0]);
    fac = (in_data.facing >= 3'd6) ? in_data.facing - 3'd2 : in_data.facing;
    eff_id = (col_r == 5'd0) ? 12'd0 : run_id_r;
    run_base_id_sy = row_r;
  end

  logic [IW-1:0] rd_idx;
  vpgqm_pkg::group_t prev_e, last_e;
  assign rd_idx = idx_r[IW-1:0];
  always_comb begin
    prev_e = sel_r ? mem_b[rd_idx] : mem_a[rd_idx];
    last_e = sel_r ? mem_b[IW'(prev_cnt_r - 1'b1)] : mem_a[IW'(prev_cnt_r - 1'b1)];
  end

  logic hit;
  assign hit = (idx_r < prev_cnt_r) && prev_e.tid == cl_id_r && prev_e.sx == cl_sx_r &&
               prev_e.ex == cl_ex_r;

  vpgqm_pkg::group_t new_g;
  always_comb begin
    new_g.tid = cl_id_r;
    new_g.sy  = hit ? prev_e.sy : cl_sy_r;
    new_g.sx  = cl_sx_r;
    new_g.ex  = cl_ex_r;
  end

  logic [16:0] sum_q;
  assign sum_q = 17'(quads_r) + 17'(prev_cnt_r);

  always_comb begin
    stat.need_close  = cl_a_r || cl_b_r;
    stat.last_col    = (col_r == LAST);
    stat.last_row    = (row_r == LAST);
    stat.scan_hit    = hit;
    stat.scan_last   = (idx_r + 1'b1 >= prev_cnt_r);
    stat.batch_empty = (prev_cnt_r == '0);
    stat.cur_empty   = (cur_cnt_r == '0);
    stat.batch_ovf   = ovf_r || (sum_q > 17'(quad_capacity));
    stat.emit_last   = (idx_r + 1'b1 >= prev_cnt_r);
    stat.out_busy    = out_valid_r && !out_ready;
  end

  // quad build
  vpgqm_pkg::out_item_t q;
  always_comb begin
    logic [4:0] a, b;
    logic [1:0] axis;
    logic       sw;
    logic [14:0] pos;
    logic [31:0] v [4];
    axis = facing_r[2:1];
    sw = (facing_r == 3'd1) || (facing_r == 3'd2) || (facing_r == 3'd5);
    for (int j = 0; j < 4; j++) begin
      if (sw) begin
        a = j[0] ? prev_e.ex : prev_e.sx;
        b = j[1] ? emit_row_r : prev_e.sy;
      end else begin
        a = j[1] ? prev_e.ex : prev_e.sx;
        b = j[0] ? emit_row_r : prev_e.sy;
      end
      if (axis == 2'd0) pos = {layer_r, a, b};
      else if (axis == 2'd1) pos = {a, layer_r, b};
      else pos = {a, b, layer_r};
      v[j] = {prev_e.tid, axis, vpgqm_pkg::corner_code(facing_r, 2'(j)), pos};
    end
    q.vertex0 = v[0];
    q.vertex1 = v[1];
    q.vertex2 = v[2];
    q.vertex3 = v[3];
    q.last_of_run = cmd.last_flag;
    q.overflow = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.close_write && cur_cnt_r < CW'(PLANE_SIZE)) begin
      if (sel_r) mem_a[cur_cnt_r[IW-1:0]] <= new_g;
      else mem_b[cur_cnt_r[IW-1:0]] <= new_g;
    end
    if (cmd.scan_step && hit) begin
      if (sel_r) mem_b[rd_idx] <= last_e;
      else mem_a[rd_idx] <= last_e;
    end
  end

  always_comb sel_nxt = cmd.swap_lists ? !sel_r : sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      prev_cnt_r <= '0;
      cur_cnt_r <= '0;
      run_id_r <= '0;
      col_r <= '0;
      row_r <= '0;
      quads_r <= '0;
      ovf_r <= 1'b0;
      idx_r <= '0;
      cl_a_r <= 1'b0;
      cl_b_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.take_item) begin
        facing_r <= fac;
        layer_r <= in_data.plane_layer;
        if (in_data.new_mesh) begin
          quads_r <= '0;
          ovf_r <= 1'b0;
        end
        idx_r <= '0;
        cl_a_r <= 1'b0;
        cl_b_r <= 1'b0;
        if (tex != eff_id) begin
          if (eff_id != 12'd0 && col_r != 5'd0) begin
            cl_a_r <= 1'b1;
            cl_id_r <= eff_id;
            cl_sx_r <= run_sx_r;
            cl_sy_r <= run_sy_r;
            cl_ex_r <= col_r - 5'd1;
          end
          run_id_r <= tex;
          run_sx_r <= col_r;
          run_sy_r <= run_base_id_sy;
        end else if (col_r == 5'd0) begin
          run_id_r <= 12'd0;
          run_sy_r <= run_base_id_sy;
        end
        if (col_r == LAST) begin
          if ((tex != eff_id) ? (tex != 12'd0) : (eff_id != 12'd0)) begin
            cl_b_r <= 1'b1;
            if (!((tex != eff_id) && eff_id != 12'd0 && col_r != 5'd0)) begin
              cl_id_r <= (tex != eff_id) ? tex : eff_id;
              cl_sx_r <= (tex != eff_id) ? col_r : run_sx_r;
              cl_sy_r <= (tex != eff_id) ? row_r : run_sy_r;
              cl_ex_r <= LAST;
            end
          end
          col_r <= '0;
          emit_row_r <= row_r - 5'd1;
        end else begin
          col_r <= col_r + 5'd1;
        end
      end
      if (cmd.scan_step) begin
        if (hit) prev_cnt_r <= prev_cnt_r - 1'b1;
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.close_write) begin
        if (cur_cnt_r < CW'(PLANE_SIZE)) cur_cnt_r <= cur_cnt_r + 1'b1;
        idx_r <= '0;
        if (cl_a_r) begin
          cl_a_r <= 1'b0;
          if (cl_b_r) begin
            cl_id_r <= run_id_r;
            cl_sx_r <= run_sx_r;
            cl_sy_r <= run_sy_r;
            cl_ex_r <= LAST;
          end
        end else begin
          cl_b_r <= 1'b0;
        end
      end
      if (cmd.emit_quad) begin
        out_r <= q;
        out_valid_r <= 1'b1;
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.emit_ovf) begin
        out_r <= '0;
        out_r.overflow <= 1'b1;
        out_r.last_of_run <= cmd.last_flag;
        out_valid_r <= 1'b1;
        ovf_r <= 1'b1;
      end
      if (cmd.batch_done) quads_r <= sum_q[15:0];
      if (cmd.swap_lists) begin
        idx_r <= '0;
        if (cmd.final_batch) begin
          prev_cnt_r <= '0;
          row_r <= '0;
        end else begin
          prev_cnt_r <= cur_cnt_r;
          cur_cnt_r <= '0;
          emit_row_r <= row_r;
          if (row_r == LAST) begin
            row_r <= row_r;
          end else begin
            row_r <= row_r + 5'd1;
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n) prev_cnt_r <= CW'(PLANE_SIZE) && cur_cnt_r <= CW'(PLANE_SIZE);
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("list count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(cmd.emit_quad || cmd.emit_ovf))
    else $error("output overwritten while stalled");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r && !cmd.take_item) |=> ovf_r) else $error("overflow flag dropped");

endmodule
`default_nettype wire

@@ rtl/core/vpgqm_ctrl.sv @@
`default_nettype none
module vpgqm_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  vpgqm_pkg::dp_stat_t  stat,
  output vpgqm_pkg::dp_cmd_t   cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLOSE = 3'd1;
  localparam logic [2:0] S_BATCH = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_SWAP  = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;
  localparam logic [2:0] S_FEMIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;     // final batch pending after swap
  logic       rowend_r, rowend_nxt;

  always_comb begin
    state_nxt = state_r;
    fin_nxt = fin_r;
    rowend_nxt = rowend_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = !stat.out_busy;
        if (in_valid && in_ready) begin
          cmd.take_item = 1'b1;
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (stat.need_close) begin
          if (stat.scan_hit || stat.scan_last) begin
            cmd.close_write = 1'b1;
          end
          if (!stat.scan_last || stat.scan_hit) cmd.scan_step = !stat.scan_last || stat.scan_hit;
        end else if (rowend_r) begin
          state_nxt = S_BATCH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_BATCH, S_FINAL: begin
        if (stat.batch_empty) begin
          state_nxt = (state_r == S_BATCH) ? S_SWAP : S_IDLE;
          if (state_r == S_FINAL) begin
            cmd.swap_lists = 1'b1;
            cmd.final_batch = 1'b1;
          end
        end else if (!stat.out_busy) begin
          if (stat.batch_ovf) begin
            cmd.emit_ovf = 1'b1;
            // last result unless a nonempty final batch still follows
            cmd.last_flag = (state_r == S_FINAL) || !fin_r || stat.cur_empty;
            if (state_r == S_FINAL) begin
              cmd.swap_lists = 1'b1;
              cmd.final_batch = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SWAP;
            end
          end else begin
            state_nxt = (state_r == S_BATCH) ? S_EMIT : S_FEMIT;
          end
        end
      end
      S_EMIT, S_FEMIT: begin
        if (!stat.out_busy) begin
          cmd.emit_quad = 1'b1;
          if (stat.emit_last) begin
            cmd.batch_done = 1'b1;
            cmd.last_flag = (state_r == S_FEMIT) || !fin_r || stat.cur_empty;
            if (state_r == S_FEMIT) begin
              cmd.swap_lists = 1'b1;
              cmd.final_batch = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_SWAP;
            end
          end
        end
      end
      S_SWAP: begin
        cmd.swap_lists = 1'b1;
        state_nxt = fin_r ? S_FINAL : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // row end / final-row detection is captured as the item is taken
    if (cmd.take_item) begin
      rowend_nxt = stat.last_col;
      fin_nxt = stat.last_col && stat.last_row;
    end
    if (state_r == S_CLOSE && !stat.need_close) rowend_nxt = 1'b0;
    if (state_r == S_SWAP) fin_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_r <= 1'b0;
      rowend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r <= fin_nxt;
      rowend_r <= rowend_nxt;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit_quad && cmd.emit_ovf)) else $error("double emit");
  a_take_close: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_item |=> state_r == S_CLOSE) else $error("item not followed by close");

endmodule
`default_nettype wire

@@ rtl/core/voxel_plane_greedy_quad_mesher_top.sv @@
`default_nettype none
// Greedy quad mesher for one 32x32 plane of voxel faces. Texels are taken one
// per transaction in raster order, a new one only when the last is fully done;
// each run that an item closes (a row-end item can close two) is matched against
// the previous-row list, one list entry compared per cycle, and a row-end item
// further emits the previous row's quads (up to 32 per batch, two batches on the
// last row). Quads leave through a single output register; the input is held off
// while a result waits there. quad_capacity (APB address 0) limits quads per
// mesh; an overflowing batch yields one zeroed result with overflow set.
module voxel_plane_greedy_quad_mesher_top #(
  parameter int PLANE_SIZE = 32,
  parameter int TEX_BITS   = 12
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  vpgqm_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output vpgqm_pkg::out_item_t  out_data,
  input  wire                   cfg_psel,
  input  wire                   cfg_penable,
  input  wire                   cfg_pwrite,
  input  wire  [1:0]            cfg_paddr,
  input  wire  [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  logic [15:0] cap_r;
  vpgqm_pkg::dp_cmd_t  cmd;
  vpgqm_pkg::dp_stat_t stat;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= vpgqm_pkg::CAP_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == vpgqm_pkg::ADDR_QUAD_CAP)
      cap_r <= cfg_pwdata[15:0];
  end
  assign cfg_prdata = (cfg_paddr == vpgqm_pkg::ADDR_QUAD_CAP) ? {16'd0, cap_r} : 32'd0;

  vpgqm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  vpgqm_dp #(.PLANE_SIZE(PLANE_SIZE), .TEX_BITS(TEX_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd),
    .quad_capacity(cap_r), .out_ready(out_ready), .stat(stat),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule
`default_nettype wire

@@ bench/vpgqm_scoreboard.sv @@
`timescale 1ns / 100ps
module vpgqm_scoreboard (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire                  in_ready,
  input  vpgqm_pkg::in_item_t  in_data,
  input  wire                  out_valid,
  input  wire                  out_ready,
  input  vpgqm_pkg::out_item_t out_data,
  input  wire                  cfg_psel,
  input  wire                  cfg_penable,
  input  wire                  cfg_pwrite,
  input  wire  [1:0]           cfg_paddr,
  input  wire  [31:0]          cfg_pwdata,
  input  wire                  cfg_pready,
  output int                   fail_count,
  output int                   quads_pending
);

  localparam int ROW_LEN = 32;

  localparam logic [2:0] CORNERS [6][4] = '{
    '{3'd4, 3'd5, 3'd6, 3'd7}, '{3'd0, 3'd2, 3'd1, 3'd3}, '{3'd2, 3'd6, 3'd3, 3'd7},
    '{3'd0, 3'd1, 3'd4, 3'd5}, '{3'd1, 3'd3, 3'd5, 3'd7}, '{3'd0, 3'd4, 3'd2, 3'd6}};

  vpgqm_pkg::out_item_t quad_q[$];
  vpgqm_pkg::group_t    prev_grp [32];
  vpgqm_pkg::group_t    cur_grp  [32];
  int          prev_cnt, cur_cnt;
  logic [11:0] run_id;
  logic [4:0]  run_sx, run_sy;
  int          col, row;
  int          mesh_quads;
  logic        mesh_ovf;
  logic [15:0] quad_cap;

  assign quads_pending = quad_q.size();

  function automatic void close_open_run(input logic [4:0] end_col);
    logic [4:0] sy;
    sy = run_sy;
    for (int i = 0; i < prev_cnt; i++) begin
      if (prev_grp[i].tid == run_id && prev_grp[i].sx == run_sx &&
          prev_grp[i].ex == end_col) begin
        sy = prev_grp[i].sy;
        prev_cnt--;
        prev_grp[i] = prev_grp[prev_cnt];
        break;
      end
    end
    if (cur_cnt < 32) begin
      cur_grp[cur_cnt] = '{tid: run_id, sy: sy, sx: run_sx, ex: end_col};
      cur_cnt++;
    end
  endfunction

  function automatic void emit_quads(input int n, input logic [4:0] ey, input logic [2:0] f,
                                     input logic [4:0] lay);
    vpgqm_pkg::out_item_t q;
    logic [4:0] a, b;
    logic [1:0] axis;
    logic [14:0] pos;
    logic [31:0] v [4];
    bit         swp;
    if (n == 0) return;
    if (mesh_ovf || mesh_quads + n > quad_cap) begin
      mesh_ovf = 1'b1;
      q = '0;
      q.overflow = 1'b1;
      quad_q.push_back(q);
      return;
    end
    axis = f[2:1];
    swp = (f == 3'd1 || f == 3'd2 || f == 3'd5);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 4; j++) begin
        if (swp) begin
          a = j[0] ? prev_grp[i].ex : prev_grp[i].sx;
          b = j[1] ? ey : prev_grp[i].sy;
        end else begin
          a = j[1] ? prev_grp[i].ex : prev_grp[i].sx;
          b = j[0] ? ey : prev_grp[i].sy;
        end
        case (axis)
          2'd0: pos = {lay, a, b};
          2'd1: pos = {a, lay, b};
          default: pos = {a, b, lay};
        endcase
        v[j] = {prev_grp[i].tid, axis, CORNERS[f][j], pos};
      end
      q = '{vertex0: v[0], vertex1: v[1], vertex2: v[2], vertex3: v[3],
            last_of_run: 1'b0, overflow: 1'b0};
      quad_q.push_back(q);
    end
    mesh_quads += n;
  endfunction

  function automatic void predict_texel(input vpgqm_pkg::in_item_t it);
    logic [2:0] f;
    int         n_prior;
    n_prior = quad_q.size();
    f = (it.facing >= 3'd6) ? it.facing - 3'd2 : it.facing;
    if (it.new_mesh) begin
      mesh_quads = 0;
      mesh_ovf = 1'b0;
    end
    if (col == 0) begin
      run_id = '0;
      run_sx = '0;
      run_sy = row[4:0];
    end
    if (it.texel_id != run_id) begin
      if (run_id != 0 && col > 0) close_open_run(5'(col - 1));
      run_id = it.texel_id;
      run_sx = col[4:0];
      run_sy = row[4:0];
    end
    if (col >= ROW_LEN - 1) begin
      if (run_id != 0) close_open_run(5'(ROW_LEN - 1));
      emit_quads(prev_cnt, 5'(row - 1), f, it.plane_layer);
      prev_grp = cur_grp;
      prev_cnt = cur_cnt;
      cur_cnt = 0;
      col = 0;
      if (row >= ROW_LEN - 1) begin
        emit_quads(prev_cnt, row[4:0], f, it.plane_layer);
        prev_cnt = 0;
        row = 0;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
    if (quad_q.size() > n_prior) quad_q[quad_q.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    vpgqm_pkg::out_item_t e;
    if (!rst_n) begin
      quad_q.delete();
      prev_cnt = 0;
      cur_cnt = 0;
      run_id = '0;
      run_sx = '0;
      run_sy = '0;
      col = 0;
      row = 0;
      mesh_quads = 0;
      mesh_ovf = 1'b0;
      quad_cap = vpgqm_pkg::CAP_RESET;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == vpgqm_pkg::ADDR_QUAD_CAP)
        quad_cap = cfg_pwdata[15:0];
      if (in_valid && in_ready) predict_texel(in_data);
      if (out_valid && out_ready) begin
        if (quad_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: unexpected quad %h", $realtime, out_data);
        end else begin
          e = quad_q.pop_front();
          if (e.vertex0 != out_data.vertex0) report("vertex0", e.vertex0, out_data.vertex0);
          if (e.vertex1 != out_data.vertex1) report("vertex1", e.vertex1, out_data.vertex1);
          if (e.vertex2 != out_data.vertex2) report("vertex2", e.vertex2, out_data.vertex2);
          if (e.vertex3 != out_data.vertex3) report("vertex3", e.vertex3, out_data.vertex3);
          if (e.last_of_run != out_data.last_of_run)
            report("last_of_run", e.last_of_run, out_data.last_of_run);
          if (e.overflow != out_data.overflow)
            report("overflow", e.overflow, out_data.overflow);
        end
      end
    end
  end

endmodule

@@ bench/tb_voxel_plane_greedy_quad_mesher_top.sv @@
`timescale 1ns / 100ps
module tb_voxel_plane_greedy_quad_mesher_top;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  vpgqm_pkg::in_item_t  in_data;
  logic        out_valid;
  logic        out_ready;
  vpgqm_pkg::out_item_t out_data;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          quads_pending;
  bit          quiet;
  bit          hold_req;
  logic [11:0] row_tex [32];
  logic [11:0] palette [4];

  voxel_plane_greedy_quad_mesher_top dut (.*);

  vpgqm_scoreboard u_scoreboard (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  task automatic cfg_write(input logic [1:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_texel(input logic [11:0] tex, input bit nm);
    vpgqm_pkg::in_item_t it;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    it.texel_id = tex;
    it.facing = 3'($urandom_range(0, 7));
    it.plane_layer = ($urandom_range(0, 3) == 0) ? 5'd31 * 5'($urandom_range(0, 1))
                                                 : 5'($urandom_range(0, 31));
    it.new_mesh = nm || ($urandom_range(0, 99) < 2);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (quads_pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // mostly copies of the previous row so groups grow, otherwise fresh runs
  task automatic make_row(input int r);
    int c, len, kind;
    logic [11:0] id;
    kind = $urandom_range(0, 99);
    if (r > 0 && kind < 55) return;
    c = 0;
    while (c < 32) begin
      len = (kind < 90) ? $urandom_range(1, 8) : 1;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 32);
      id = ($urandom_range(0, 3) == 0) ? 12'd0 : palette[$urandom_range(0, 3)];
      if (kind >= 95) id = 12'($urandom);
      for (int k = 0; k < len && c < 32; k++) begin
        row_tex[c] = id;
        c++;
      end
    end
  endtask

  // eight full rows and half of a ninth
  task automatic run_rows();
    for (int k = 0; k < 4; k++) palette[k] = 12'($urandom_range(1, 4095));
    for (int r = 0; r < 9; r++) begin
      if (r < 4) begin
        for (int c = 0; c < 32; c++)
          row_tex[c] = (r < 2) ? 12'hfff : (r == 2) ? 12'(c[0] ? 1 : 2048) : 12'd0;
      end else begin
        make_row(r);
      end
      quiet = (r == 2 || r == 3);
      // row 3 ends with a burst of quads that lands in the hold-off
      if (r == 4) hold_req = 1'b1;
      if (r == 5) begin
        drain();
        cfg_write(vpgqm_pkg::ADDR_QUAD_CAP, 32'd0);
      end
      if (r == 7) begin
        drain();
        cfg_write(vpgqm_pkg::ADDR_QUAD_CAP, 32'd3);
      end
      for (int c = 0; c < ((r == 8) ? 16 : 32); c++)
        send_texel(row_tex[c], (r == 7 && c == 0));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    for (int c = 0; c < 32; c++) row_tex[c] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(vpgqm_pkg::ADDR_QUAD_CAP, 32'hffff);
    run_rows();
    drain();
    if (fail_count == 0 && quads_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
